FILE: rtl/lbbs_pkg.sv
// Shared types and constants for the largest-box bisection splitter.
// Used by lbbs_ctrl, lbbs_datapath and the top level; depends on nothing.
package lbbs_pkg;

    localparam int MaxBoxes = 64;
    localparam int AddrW    = $clog2(MaxBoxes);
    localparam int CntW     = $clog2(MaxBoxes + 1);
    localparam int CoordW   = 12;
    localparam int HighW    = 13;
    localparam int VolW     = 37;
    localparam int TotW     = 43;
    localparam int TgtW     = 7;
    localparam int ProcW    = 13;
    localparam int CfgW     = 13;
    localparam int DivCntW  = $clog2(TotW);
    localparam int WordW    = 3 * CoordW + 3 * HighW + VolW;

    localparam logic [HighW-1:0] CoordLimit = 13'd4096;

    // Configuration register indexes.
    localparam logic RegTarget = 1'b0;
    localparam logic RegProcs  = 1'b1;

    typedef logic [2:0][CoordW-1:0] t_lo;
    typedef logic [2:0][HighW-1:0]  t_hi;

    typedef struct packed {
        logic cap_in;
        logic ovf_set;
        logic p1;
        logic mul2;
        logic ld_wr;
        logic run_init;
        logic div_step;
        logic scan_go;
        logic emit;
        logic cap_set;
        logic split_cap;
        logic wr_src;
        logic wr_dst;
        logic emit_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic div_last;
        logic scan_done;
        logic want;
        logic max_le1;
    } t_sts;

endpackage

FILE: rtl/lbbs_ctrl.sv
// Sequencer for loads, the threshold divide, the split loop and the emit walk.
// Depends on lbbs_pkg; drives lbbs_datapath through t_cmd.
module lbbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_action,
    input  lbbs_pkg::t_sts i_sts,
    output lbbs_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import lbbs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LP1   = 4'd1;
    localparam logic [3:0] S_LMUL  = 4'd2;
    localparam logic [3:0] S_LWR   = 4'd3;
    localparam logic [3:0] S_EMPTY = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SA    = 4'd9;
    localparam logic [3:0] S_SB    = 4'd10;
    localparam logic [3:0] S_SMUL  = 4'd11;
    localparam logic [3:0] S_WSRC  = 4'd12;
    localparam logic [3:0] S_WDST  = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_action) begin
                    if (i_sts.full) begin
                        o_cmd.ovf_set = 1'b1;
                    end else begin
                        o_cmd.cap_in = 1'b1;
                        n_state = S_LP1;
                    end
                end else if (accept) begin
                    if (i_sts.empty) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd.run_init = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_LP1: begin
                o_cmd.p1 = 1'b1;
                n_state = S_LMUL;
            end
            S_LMUL: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_LWR;
            end
            S_LWR: begin
                o_cmd.ld_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_EMPTY: begin
                o_cmd.emit_empty = 1'b1;
                o_cmd.clear = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_go = 1'b1;
                if (i_sts.scan_done) n_state = S_DEC;
            end
            S_DEC: begin
                if (!i_sts.want || i_sts.max_le1) begin
                    n_state = S_EMIT;
                end else if (i_sts.full) begin
                    o_cmd.cap_set = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: n_state = S_SA;
            S_SA: begin
                o_cmd.split_cap = 1'b1;
                n_state = S_SB;
            end
            S_SB: begin
                o_cmd.p1 = 1'b1;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_WSRC;
            end
            S_WSRC: begin
                o_cmd.wr_src = 1'b1;
                n_state = S_WDST;
            end
            S_WDST: begin
                o_cmd.wr_dst = 1'b1;
                n_state = S_SCAN;
            end
            S_EMIT: begin
                o_cmd.scan_go = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/lbbs_datapath.sv
// Box store, volume multiplier, threshold divider, largest-box scan and cut logic.
// Depends on lbbs_pkg; commanded by lbbs_ctrl.
module lbbs_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbbs_pkg::t_cmd              i_cmd,
    output lbbs_pkg::t_sts              o_sts,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [lbbs_pkg::CfgW-1:0]   i_cfg_data,
    input  logic [lbbs_pkg::CoordW-1:0] i_in_low_x,
    input  logic [lbbs_pkg::CoordW-1:0] i_in_low_y,
    input  logic [lbbs_pkg::CoordW-1:0] i_in_low_z,
    input  logic [lbbs_pkg::HighW-1:0]  i_in_high_x,
    input  logic [lbbs_pkg::HighW-1:0]  i_in_high_y,
    input  logic [lbbs_pkg::HighW-1:0]  i_in_high_z,
    output logic                        o_valid,
    output logic [lbbs_pkg::CoordW-1:0] o_out_low_x,
    output logic [lbbs_pkg::CoordW-1:0] o_out_low_y,
    output logic [lbbs_pkg::CoordW-1:0] o_out_low_z,
    output logic [lbbs_pkg::HighW-1:0]  o_out_high_x,
    output logic [lbbs_pkg::HighW-1:0]  o_out_high_y,
    output logic [lbbs_pkg::HighW-1:0]  o_out_high_z,
    output logic [lbbs_pkg::VolW-1:0]   o_box_volume,
    output logic                        o_capped,
    output logic                        o_empty_set,
    output logic                        o_last
);
    import lbbs_pkg::*;

    logic [WordW-1:0] mem [MaxBoxes];

    // Control state.
    logic [CntW-1:0]    r_count;
    logic [TotW-1:0]    r_total;
    logic               r_ovf;
    logic               r_capped;
    logic [TgtW-1:0]    r_target;
    logic [ProcW-1:0]   r_procs;
    logic [CntW-1:0]    r_sidx;
    logic               r_svalid;
    logic               r_sem;
    logic [DivCntW-1:0] r_dcnt;

    // Payload.
    logic [WordW-1:0]   r_rd;
    logic [AddrW-1:0]   r_sidx_d;
    logic [VolW-1:0]    r_max;
    logic [AddrW-1:0]   r_big;
    logic [TotW-1:0]    r_q;
    logic [ProcW:0]     r_rem;
    logic [ProcW-1:0]   r_div;
    t_lo                r_wlo;
    t_hi                r_whi;
    t_lo                r_slo;
    t_hi                r_shi;
    logic [VolW-1:0]    r_svol;
    logic [2*HighW-1:0] r_p1;
    logic [HighW-1:0]   r_ez;
    logic [VolW-1:0]    r_vol;

    // Load corner clamp.
    t_lo in_lo;
    t_hi in_hi_raw, in_hi;
    always_comb begin
        in_lo     = {i_in_low_z, i_in_low_y, i_in_low_x};
        in_hi_raw = {i_in_high_z, i_in_high_y, i_in_high_x};
        for (int d = 0; d < 3; d++) begin
            in_hi[d] = (in_hi_raw[d] > CoordLimit) ? CoordLimit : in_hi_raw[d];
            if (in_hi[d] <= {1'b0, in_lo[d]}) in_hi[d] = {1'b0, in_lo[d]} + 1'b1;
        end
    end

    // Fields of the word last read.
    t_lo             rd_lo;
    t_hi             rd_hi;
    logic [VolW-1:0] rd_vol;
    assign rd_lo  = r_rd[3*CoordW-1:0];
    assign rd_hi  = r_rd[3*CoordW+3*HighW-1:3*CoordW];
    assign rd_vol = r_rd[WordW-1:3*CoordW+3*HighW];

    // Longest axis and midpoint of the box being cut; ties go to the lower axis.
    logic [2:0][HighW-1:0] rd_ext;
    logic [1:0]            axis;
    logic [HighW:0]        mid_sum;
    logic [HighW-1:0]      mid;
    t_lo                   cut_lo;
    t_hi                   cut_hi;
    always_comb begin
        for (int d = 0; d < 3; d++) rd_ext[d] = rd_hi[d] - {1'b0, rd_lo[d]};
        axis = 2'd0;
        if (rd_ext[1] > rd_ext[0] && rd_ext[1] > 13'd1) axis = 2'd1;
        if (rd_ext[2] > rd_ext[axis] && rd_ext[2] > 13'd1) axis = 2'd2;
        mid_sum = {1'b0, rd_hi[axis]} + {2'b0, rd_lo[axis]};
        mid     = mid_sum[HighW:1];
        // The source keeps the lower half, the new box takes the upper half.
        cut_hi       = rd_hi;
        cut_hi[axis] = mid;
        cut_lo       = rd_lo;
        cut_lo[axis] = mid[CoordW-1:0];
    end

    logic [2:0][HighW-1:0] w_ext;
    always_comb begin
        for (int d = 0; d < 3; d++) w_ext[d] = r_whi[d] - {1'b0, r_wlo[d]};
    end

    logic [3*HighW-1:0] vol_full;
    assign vol_full = {{HighW{1'b0}}, r_p1} * {{2*HighW{1'b0}}, r_ez};

    // Divider step: restoring, one quotient bit a cycle.
    logic [ProcW:0] rem_sh;
    logic           q_bit;
    assign rem_sh = {r_rem[ProcW-1:0], r_q[TotW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_div});

    logic [TgtW-1:0] tgt_eff;
    assign tgt_eff = (r_target == '0) ? TgtW'(1) : r_target;

    assign o_sts.full      = (r_count >= CntW'(MaxBoxes));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.div_last  = (r_dcnt == DivCntW'(TotW - 1));
    assign o_sts.scan_done = r_svalid && ({1'b0, r_sidx_d} == r_count - 1'b1);
    assign o_sts.want      = (r_count < CntW'(tgt_eff)) ||
                             ({{(TotW-VolW){1'b0}}, r_max} > r_q);
    assign o_sts.max_le1   = (r_max <= VolW'(1));

    // Memory: one write port, one registered read port.
    logic [AddrW-1:0] rd_addr, wr_addr;
    logic [WordW-1:0] wr_data;
    logic             wr_en;
    always_comb begin
        rd_addr = i_cmd.scan_go ? r_sidx[AddrW-1:0] : r_big;
        wr_en   = i_cmd.ld_wr || i_cmd.wr_dst || i_cmd.wr_src;
        if (i_cmd.wr_src) begin
            wr_addr = r_big;
            wr_data = {r_svol - r_vol, r_shi, r_slo};
        end else begin
            wr_addr = r_count[AddrW-1:0];
            wr_data = {r_vol, r_whi, r_wlo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_capped <= 1'b0;
            r_target <= TgtW'(1);
            r_procs  <= ProcW'(1);
            r_sidx   <= '0;
            r_svalid <= 1'b0;
            r_sem    <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == RegTarget) r_target <= i_cfg_data[TgtW-1:0];
            if (i_cfg_we && i_cfg_idx == RegProcs)  r_procs  <= i_cfg_data[ProcW-1:0];
            if (i_cmd.ovf_set) r_ovf <= 1'b1;
            if (i_cmd.ld_wr) r_total <= r_total + {{(TotW-VolW){1'b0}}, r_vol};
            if (i_cmd.ld_wr || i_cmd.wr_dst) r_count <= r_count + 1'b1;
            if (i_cmd.run_init) begin
                r_capped <= r_ovf;
                r_dcnt   <= '0;
            end
            if (i_cmd.div_step) r_dcnt <= r_dcnt + 1'b1;
            if (i_cmd.cap_set) r_capped <= 1'b1;
            r_sidx   <= i_cmd.scan_go ? r_sidx + 1'b1 : '0;
            r_svalid <= i_cmd.scan_go && (r_sidx < r_count);
            r_sem    <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_total <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sidx_d <= r_sidx[AddrW-1:0];
        if (i_cmd.cap_in) begin
            r_wlo <= in_lo;
            r_whi <= in_hi;
        end
        if (i_cmd.split_cap) begin
            r_slo  <= rd_lo;
            r_shi  <= cut_hi;
            r_svol <= rd_vol;
            r_wlo  <= cut_lo;
            r_whi  <= rd_hi;
        end
        if (i_cmd.p1) begin
            r_p1 <= {{HighW{1'b0}}, w_ext[0]} * {{HighW{1'b0}}, w_ext[1]};
            r_ez <= w_ext[2];
        end
        if (i_cmd.mul2) r_vol <= vol_full[VolW-1:0];
        if (i_cmd.run_init) begin
            r_q   <= r_total;
            r_rem <= '0;
            r_div <= (r_procs == '0) ? ProcW'(1) : r_procs;
        end
        if (i_cmd.div_step) begin
            r_q   <= {r_q[TotW-2:0], q_bit};
            r_rem <= q_bit ? rem_sh - {1'b0, r_div} : rem_sh;
        end
        // Strict compare keeps the earliest box among equal volumes.
        if (r_svalid && (r_sidx_d == '0 || rd_vol > r_max)) begin
            r_max <= rd_vol;
            r_big <= r_sidx_d;
        end
    end

    logic emit_beat;
    assign emit_beat = r_svalid && r_sem;

    always_comb begin
        o_valid      = emit_beat || i_cmd.emit_empty;
        o_out_low_x  = emit_beat ? rd_lo[0] : '0;
        o_out_low_y  = emit_beat ? rd_lo[1] : '0;
        o_out_low_z  = emit_beat ? rd_lo[2] : '0;
        o_out_high_x = emit_beat ? rd_hi[0] : '0;
        o_out_high_y = emit_beat ? rd_hi[1] : '0;
        o_out_high_z = emit_beat ? rd_hi[2] : '0;
        o_box_volume = emit_beat ? rd_vol : '0;
        o_capped     = i_cmd.emit_empty ? r_ovf : r_capped;
        o_empty_set  = i_cmd.emit_empty;
        o_last       = i_cmd.emit_empty || (emit_beat && o_sts.scan_done);
    end

endmodule

FILE: rtl/largest_box_bisection_splitter.sv
// Top level of the largest-box bisection splitter.
// Depends on lbbs_pkg, lbbs_ctrl and lbbs_datapath.
//
// Usage: an item is taken when start is high and busy is low. A load item
// (action 0) stores one box in order: clamp, two multiplier stages for the
// volume, and the store write. A load into a full store only marks the run
// as capped.
// A run item (action 1) divides the volume total by the processor count (one
// quotient bit a cycle), then repeats: scan the store for the largest box
// (one store read a cycle), decide, and cut (through the single store port
// and multiplier). It ends with one result beat per stored box on consecutive
// cycles, o_valid high and o_last on the final beat, after which the store is
// empty. A run on an empty store gives a single beat with o_empty_set.
// Result beats are shown for one cycle each; the receiver cannot stall.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block itself does not enforce it.
// Reset (synchronous, active low) empties the store and sets both registers
// to one; the store contents themselves are not cleared.
module largest_box_bisection_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [lbbs_pkg::CfgW-1:0]   i_cfg_data,
    input  logic                        i_action,
    input  logic [lbbs_pkg::CoordW-1:0] i_in_low_x,
    input  logic [lbbs_pkg::CoordW-1:0] i_in_low_y,
    input  logic [lbbs_pkg::CoordW-1:0] i_in_low_z,
    input  logic [lbbs_pkg::HighW-1:0]  i_in_high_x,
    input  logic [lbbs_pkg::HighW-1:0]  i_in_high_y,
    input  logic [lbbs_pkg::HighW-1:0]  i_in_high_z,
    output logic                        o_valid,
    output logic [lbbs_pkg::CoordW-1:0] o_out_low_x,
    output logic [lbbs_pkg::CoordW-1:0] o_out_low_y,
    output logic [lbbs_pkg::CoordW-1:0] o_out_low_z,
    output logic [lbbs_pkg::HighW-1:0]  o_out_high_x,
    output logic [lbbs_pkg::HighW-1:0]  o_out_high_y,
    output logic [lbbs_pkg::HighW-1:0]  o_out_high_z,
    output logic [lbbs_pkg::VolW-1:0]   o_box_volume,
    output logic                        o_capped,
    output logic                        o_empty_set,
    output logic                        o_last
);
    import lbbs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lbbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lbbs_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_low_x   (i_in_low_x),
        .i_in_low_y   (i_in_low_y),
        .i_in_low_z   (i_in_low_z),
        .i_in_high_x  (i_in_high_x),
        .i_in_high_y  (i_in_high_y),
        .i_in_high_z  (i_in_high_z),
        .o_valid      (o_valid),
        .o_out_low_x  (o_out_low_x),
        .o_out_low_y  (o_out_low_y),
        .o_out_low_z  (o_out_low_z),
        .o_out_high_x (o_out_high_x),
        .o_out_high_y (o_out_high_y),
        .o_out_high_z (o_out_high_z),
        .o_box_volume (o_box_volume),
        .o_capped     (o_capped),
        .o_empty_set  (o_empty_set),
        .o_last       (o_last)
    );

`ifndef SYNTH
    a_beat_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result beat while idle");
    a_last_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without a result beat");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !busy) else $error("block still busy after last beat");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty_set |-> o_last) else $error("empty result not final");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for largest_box_bisection_splitter.
// Depends on lbbs_pkg and the RTL. It predicts every beat in its own model of the box store.
module tb_top;
    import lbbs_pkg::*;

    typedef struct packed {
        logic [11:0] lx, ly, lz;
        logic [12:0] hx, hy, hz;
        logic [36:0] vol;
        logic        cap, emp, last;
    } box_beat_t;

    typedef struct {
        logic        act;
        logic [11:0] lo [3];
        logic [12:0] hi [3];
        logic        chk;
        box_beat_t   want;
    } stim_row_t;

    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic i_cfg_we = 0, i_cfg_idx = 0;
    logic [12:0] i_cfg_data = 0;
    logic i_action = 0;
    logic [11:0] i_in_low_x = 0, i_in_low_y = 0, i_in_low_z = 0;
    logic [12:0] i_in_high_x = 1, i_in_high_y = 1, i_in_high_z = 1;
    logic o_valid, o_capped, o_empty_set, o_last;
    logic [11:0] o_out_low_x, o_out_low_y, o_out_low_z;
    logic [12:0] o_out_high_x, o_out_high_y, o_out_high_z;
    logic [36:0] o_box_volume;

    largest_box_bisection_splitter uut (.*);

    always #5 i_clk = ~i_clk;

    // Predicted box store and registers.
    logic [11:0] st_lo [64][3];
    logic [12:0] st_hi [64][3];
    logic [36:0] st_vol [64];
    int          st_cnt;
    logic [42:0] st_total;
    logic        st_ovf;
    logic [6:0]  reg_target;
    logic [12:0] reg_procs;

    box_beat_t expected_boxes [$];
    int        run_sizes [$];
    int        errors = 0;
    int        idle_pct = 0;
    longint    cycles = 0;

    function automatic logic [36:0] vol_of(int k);
        return 37'(st_hi[k][0] - st_lo[k][0]) * 37'(st_hi[k][1] - st_lo[k][1])
             * 37'(st_hi[k][2] - st_lo[k][2]);
    endfunction

    task automatic predict_item(logic act, logic [11:0] lo [3], logic [12:0] hi [3]);
        logic [12:0] h, ext [3];
        logic [13:0] mid;
        logic [42:0] thr;
        logic [12:0] procs;
        logic [6:0]  tgt;
        logic        cap;
        int big, axis, dst;
        box_beat_t b;
        if (!act) begin
            if (st_cnt >= 64) begin
                st_ovf = 1;
                return;
            end
            for (int d = 0; d < 3; d++) begin
                h = hi[d];
                if (h > 13'd4096) h = 13'd4096;
                if (h <= {1'b0, lo[d]}) h = {1'b0, lo[d]} + 13'd1;
                st_lo[st_cnt][d] = lo[d];
                st_hi[st_cnt][d] = h;
            end
            st_vol[st_cnt] = vol_of(st_cnt);
            st_total += 43'(st_vol[st_cnt]);
            st_cnt++;
            return;
        end
        if (st_cnt == 0) begin
            b = '0;
            b.cap = st_ovf;
            b.emp = 1;
            b.last = 1;
            expected_boxes = {expected_boxes, b};
            run_sizes = {run_sizes, 1};
            st_ovf = 0;
            st_total = 0;
            return;
        end
        procs = reg_procs == 0 ? 13'd1 : reg_procs;
        tgt = reg_target == 0 ? 7'd1 : reg_target;
        thr = st_total / 43'(procs);
        cap = st_ovf;
        forever begin
            big = 0;
            for (int k = 1; k < st_cnt; k++)
                if (st_vol[k] > st_vol[big]) big = k;
            if (!(st_cnt < tgt || 43'(st_vol[big]) > thr)) break;
            if (st_vol[big] <= 1) break;
            if (st_cnt >= 64) begin
                cap = 1;
                break;
            end
            for (int d = 0; d < 3; d++) ext[d] = st_hi[big][d] - st_lo[big][d];
            axis = 0;
            for (int d = 1; d < 3; d++)
                if (ext[d] > ext[axis] && ext[d] > 1) axis = d;
            mid = (14'(st_hi[big][axis]) + 14'(st_lo[big][axis])) / 2;
            dst = st_cnt;
            st_lo[dst] = st_lo[big];
            st_hi[dst] = st_hi[big];
            st_lo[dst][axis] = mid[11:0];
            st_hi[big][axis] = mid[12:0];
            st_vol[dst] = vol_of(dst);
            st_vol[big] -= st_vol[dst];
            st_cnt++;
        end
        for (int k = 0; k < st_cnt; k++) begin
            b.lx = st_lo[k][0]; b.ly = st_lo[k][1]; b.lz = st_lo[k][2];
            b.hx = st_hi[k][0]; b.hy = st_hi[k][1]; b.hz = st_hi[k][2];
            b.vol = st_vol[k];
            b.cap = cap;
            b.emp = 0;
            b.last = (k == st_cnt - 1);
            expected_boxes = {expected_boxes, b};
        end
        run_sizes = {run_sizes, st_cnt};
        st_cnt = 0;
        st_total = 0;
        st_ovf = 0;
    endtask

    // Beats of one run may come in any order; match within the run, last on the final one.
    always @(posedge i_clk) begin
        box_beat_t got, ref_b;
        int n, hit;
        cycles++;
        if (o_valid) begin
            got = '{o_out_low_x, o_out_low_y, o_out_low_z, o_out_high_x, o_out_high_y,
                    o_out_high_z, o_box_volume, o_capped, o_empty_set, o_last};
            if (expected_boxes.size() == 0) begin
                $error("unexpected beat: volume %0d", got.vol);
                errors++;
            end else begin
                n = run_sizes[0];
                hit = 0;
                for (int j = 0; j < n; j++) begin
                    ref_b = expected_boxes[j];
                    ref_b.last = got.last;
                    if (ref_b == got) begin
                        hit = j;
                        break;
                    end
                end
                ref_b = expected_boxes[hit];
                ref_b.last = (n == 1);
                if (got.lx != ref_b.lx) $error("out_low_x exp %0d got %0d", ref_b.lx, got.lx);
                if (got.ly != ref_b.ly) $error("out_low_y exp %0d got %0d", ref_b.ly, got.ly);
                if (got.lz != ref_b.lz) $error("out_low_z exp %0d got %0d", ref_b.lz, got.lz);
                if (got.hx != ref_b.hx) $error("out_high_x exp %0d got %0d", ref_b.hx, got.hx);
                if (got.hy != ref_b.hy) $error("out_high_y exp %0d got %0d", ref_b.hy, got.hy);
                if (got.hz != ref_b.hz) $error("out_high_z exp %0d got %0d", ref_b.hz, got.hz);
                if (got.vol != ref_b.vol) $error("box_volume exp %0d got %0d", ref_b.vol, got.vol);
                if (got.cap != ref_b.cap) $error("capped exp %0d got %0d", ref_b.cap, got.cap);
                if (got.emp != ref_b.emp) $error("empty_set exp %0d got %0d", ref_b.emp, got.emp);
                if (got.last != ref_b.last) $error("last exp %0d got %0d", ref_b.last, got.last);
                if (got != ref_b) errors++;
                expected_boxes.delete(hit);
                run_sizes[0]--;
                if (run_sizes[0] == 0) void'(run_sizes.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("largest_box_bisection_splitter verification failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(logic act, logic [11:0] lo [3], logic [12:0] hi [3]);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_action = act;
        i_in_low_x = lo[0]; i_in_low_y = lo[1]; i_in_low_z = lo[2];
        i_in_high_x = hi[0]; i_in_high_y = hi[1]; i_in_high_z = hi[2];
        start = 1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_item(act, lo, hi);
        @(negedge i_clk);
    endtask

    task automatic drain(int extra);
        start = 0;
        while (expected_boxes.size() != 0 || busy) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        drain(12);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        if (idx == RegTarget) reg_target = val[6:0];
        else reg_procs = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic rand_box(bit wide, output logic [11:0] lo [3], output logic [12:0] hi [3]);
        for (int d = 0; d < 3; d++) begin
            if (wide) begin
                lo[d] = 12'($urandom);
                hi[d] = 13'($urandom);
            end else begin
                lo[d] = 12'($urandom_range(4080));
                hi[d] = 13'(lo[d]) + 13'($urandom_range(1, 12));
            end
        end
    endtask

    stim_row_t rows [$];

    task automatic add_row(logic act, int lx, int ly, int lz, int hx, int hy, int hz,
                           logic chk = 0, box_beat_t want = '0);
        stim_row_t r;
        r.act = act;
        r.lo = '{12'(lx), 12'(ly), 12'(lz)};
        r.hi = '{13'(hx), 13'(hy), 13'(hz)};
        r.chk = chk;
        r.want = want;
        rows = {rows, r};
    endtask

    initial begin
        logic [11:0] lo [3];
        logic [12:0] hi [3];
        int nload;
        st_cnt = 0; st_total = 0; st_ovf = 0;
        reg_target = 1; reg_procs = 1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        add_row(1, 0, 0, 0, 1, 1, 1, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1});
        add_row(0, 0, 0, 0, 1, 1, 1);
        add_row(1, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 1, 1, 1, 1, 0, 0, 1});
        add_row(0, 4095, 4095, 4095, 8191, 8191, 8191);
        add_row(1, 0, 0, 0, 0, 0, 0, 1,
                '{4095, 4095, 4095, 4096, 4096, 4096, 1, 0, 0, 1});
        add_row(0, 9, 7, 5, 3, 0, 5);
        add_row(1, 0, 0, 0, 0, 0, 0, 1, '{9, 7, 5, 10, 8, 6, 1, 0, 0, 1});
        add_row(0, 0, 0, 0, 4096, 4096, 4096);
        add_row(1, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 4096, 4096, 4096, 37'h1000000000, 0, 0, 1});
        add_row(0, 0, 0, 0, 8, 8, 8);
        add_row(0, 0, 0, 0, 2, 2, 2);
        add_row(0, 100, 0, 0, 101, 7, 3);
        add_row(1, 0, 0, 0, 0, 0, 0);
        foreach (rows[i]) begin
            send_item(rows[i].act, rows[i].lo, rows[i].hi);
            if (rows[i].chk && expected_boxes[$] != rows[i].want) begin
                $error("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end

        // Splitting with a target and many processors.
        write_reg(RegTarget, 7'd5);
        write_reg(RegProcs, 13'd8191);
        add_row(0, 0, 0, 0, 16, 4, 4);
        add_row(0, 3, 3, 3, 4, 4, 9);
        add_row(1, 0, 0, 0, 0, 0, 0);
        for (int i = rows.size() - 3; i < rows.size(); i++)
            send_item(rows[i].act, rows[i].lo, rows[i].hi);

        // Target out of reach, zero registers, and an overfull store.
        write_reg(RegTarget, 7'd127);
        write_reg(RegProcs, 13'd0);
        for (int k = 0; k < 66; k++) begin
            rand_box(0, lo, hi);
            send_item(0, lo, hi);
        end
        send_item(1, lo, hi);
        write_reg(RegTarget, 7'd0);
        rand_box(1, lo, hi);
        send_item(0, lo, hi);
        send_item(1, lo, hi);

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(RegTarget, $urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(1, 8)));
            write_reg(RegProcs, $urandom_range(1) ? 13'($urandom) : 13'($urandom_range(1, 4)));
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 64 : 7;
            for (int s = 0; s < 3; s++) begin
                if ($urandom_range(9) == 0) begin
                    // Noise: random action and full-range fields.
                    rand_box(1, lo, hi);
                    send_item(1'($urandom_range(1)), lo, hi);
                end else begin
                    nload = $urandom_range(0, 5);
                    for (int k = 0; k < nload; k++) begin
                        rand_box($urandom_range(4) == 0, lo, hi);
                        send_item(0, lo, hi);
                    end
                    send_item(1, lo, hi);
                end
                if (ph == 5 && s == 1) drain(0);
            end
        end

        drain(200);
        if (errors == 0)
            $display("largest_box_bisection_splitter verification clean");
        else
            $display("largest_box_bisection_splitter verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/lbbs_pkg.sv
rtl/lbbs_ctrl.sv
rtl/lbbs_datapath.sv
rtl/largest_box_bisection_splitter.sv
tb/tb_top.sv
